// ===== rtl/core/bwa_pkg.sv =====
`default_nettype none

package bwa_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 24;

	localparam int WINDOW_BITS     = 24;
	localparam int PERIOD_BITS     = 16;
	localparam int PERIOD_OUT_BITS = 32;
	localparam int CFG_IDX_BITS    = 8;
	localparam int CFG_DATA_BITS   = 32;

	localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(1000);
	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(100);

	// q16 threshold factors, one extra bit so they stay positive as signed operands
	localparam int FACTOR_BITS = 17;
	localparam int FRAC_BITS   = 16;
	localparam int ROUND_BIAS  = 32768;
	localparam logic signed [FACTOR_BITS-1:0] LO_FACTOR = FACTOR_BITS'(6554);
	localparam logic signed [FACTOR_BITS-1:0] HI_FACTOR = FACTOR_BITS'(58982);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WINDOW   = CFG_IDX_BITS'(0),
		REG_PERIOD   = CFG_IDX_BITS'(1),
		REG_INIT_MIN = CFG_IDX_BITS'(2),
		REG_INIT_MAX = CFG_IDX_BITS'(3)
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/bwa_if.sv =====
`default_nettype none

interface bwa_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [bwa_pkg::CFG_IDX_BITS-1:0]   index;
	logic [bwa_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface bwa_smp_if #(
	parameter int SAMPLE_BITS = bwa_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface

interface bwa_res_if #(
	parameter int SAMPLE_BITS = bwa_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = bwa_pkg::COUNT_BITS_DEF
);
	logic                                  valid;
	logic                                  ready;
	logic signed [SAMPLE_BITS-1:0]         held_min;
	logic signed [SAMPLE_BITS-1:0]         held_max;
	logic signed [SAMPLE_BITS-1:0]         low_threshold;
	logic signed [SAMPLE_BITS-1:0]         high_threshold;
	logic                                  in_burst;
	logic [COUNT_BITS-1:0]                 burst_count;
	logic [COUNT_BITS-1:0]                 point_count;
	logic [bwa_pkg::PERIOD_OUT_BITS-1:0]   burst_period_us;
	logic                                  period_valid;
	logic                                  window_closed;

	modport source (output valid, held_min, held_max, low_threshold, high_threshold,
		in_burst, burst_count, point_count, burst_period_us, period_valid,
		window_closed, input ready);
	modport sink (input valid, held_min, held_max, low_threshold, high_threshold,
		in_burst, burst_count, point_count, burst_period_us, period_valid,
		window_closed, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bwa_div.sv =====
`default_nettype none

module bwa_div #(
	parameter int NUM_W = bwa_pkg::COUNT_BITS_DEF + bwa_pkg::PERIOD_BITS,
	parameter int DEN_W = bwa_pkg::COUNT_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);
	import bwa_pkg::*;

	localparam int CW = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             fits;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff : shifted;
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/burst_window_analyzer_core.sv =====
// burst window analyzer
//
// cfg: register writes (0 window_samples, 1 sample_period_us, 2 initial_min,
//   3 initial_max); always ready; user must write only while the block is idle
//   (not enforced). writing initial_min/max loads the held value at once.
// smp: one signed sample per request; res: one result per sample.
// a sample is taken only in the idle state and not while a register write is
// offered, so one sample is in work at a time.
// a sample that does not close a window, or closes one with no burst onset,
// goes through TLO, THI, THR and FIN: the shared multiplier runs the two
// threshold products, then the burst detector and counters update as the
// result is registered, and the next request is taken back in idle.
// a sample that closes a window with onsets also runs the product
// interval_sum * sample_period_us and a restoring divider, one quotient bit per
// cycle, in MUL, DIV_GO and DIV_WAIT before the threshold products.
// the result register holds a finished result while res is stalled; the next
// sample is accepted meanwhile and waits in its last step until the slot frees.
// reset (arst_n low) sets the registers to 1000, 100, 0, 0, clears counters,
// burst flag and latched period, and sets the running min/max to the extremes.
`default_nettype none

module burst_window_analyzer_core #(
	parameter int SAMPLE_BITS = bwa_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = bwa_pkg::COUNT_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bwa_cfg_if.sink   cfg,
	bwa_smp_if.sink   smp,
	bwa_res_if.source res
);
	import bwa_pkg::*;

	localparam int S     = SAMPLE_BITS;
	localparam int CNT_W = COUNT_BITS;
	localparam int CMP_W = (CNT_W > WINDOW_BITS) ? CNT_W : WINDOW_BITS;
	localparam int NUM_W = CNT_W + PERIOD_BITS;
	localparam int MA_W  = (CNT_W + 1 > S + 2) ? CNT_W + 1 : S + 2;
	localparam int MB_W  = FACTOR_BITS;
	localparam int P_W   = MA_W + MB_W;
	localparam int QW    = ((NUM_W > PERIOD_OUT_BITS) ? NUM_W : PERIOD_OUT_BITS) + 1;

	localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
	localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_TLO,
		ST_THI,
		ST_THR,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration and window state
	logic [WINDOW_BITS-1:0]     window_q;
	logic [PERIOD_BITS-1:0]     period_q;
	logic signed [S-1:0]        run_min_q;
	logic signed [S-1:0]        run_max_q;
	logic signed [S-1:0]        lmin_q;
	logic signed [S-1:0]        lmax_q;
	logic [CNT_W-1:0]           seen_q;
	logic [CNT_W-1:0]           onsets_q;
	logic [CNT_W-1:0]           isum_q;
	logic [CNT_W-1:0]           last_q;
	logic                       burst_q;
	logic [PERIOD_OUT_BITS-1:0] lperiod_q;
	logic                       lvalid_q;
	logic                       closed_q;
	logic                       ovalid_q;

	// working registers
	logic signed [S-1:0]        s_q;
	logic signed [S-1:0]        lo_q;
	logic signed [S-1:0]        hi_q;
	logic signed [P_W-1:0]      prod_q;
	logic [CNT_W-1:0]           num_q;
	logic [CNT_W-1:0]           den_q;

	// result register payload
	logic signed [S-1:0]        o_min_q;
	logic signed [S-1:0]        o_max_q;
	logic signed [S-1:0]        o_lo_q;
	logic signed [S-1:0]        o_hi_q;
	logic                       o_burst_q;
	logic [CNT_W-1:0]           o_onsets_q;
	logic [CNT_W-1:0]           o_seen_q;

	logic                       accept;
	logic                       close;
	logic                       fin_load;

	logic signed [S:0]          range_w;
	logic signed [MA_W-1:0]     mul_a;
	logic signed [MB_W-1:0]     mul_b;
	logic signed [P_W-1:0]      rnd;
	logic signed [P_W-1:0]      thr_sum;
	logic signed [S-1:0]        thr_val;

	logic                       div_start;
	logic                       div_done;
	logic [NUM_W-1:0]           div_quo;
	logic [QW-1:0]              quo_ext;
	logic [PERIOD_OUT_BITS-1:0] period_sat;

	logic                       onset;
	logic                       release_b;
	logic [CNT_W-1:0]           gap;
	logic [CNT_W:0]             isum_sum;
	logic [CNT_W-1:0]           isum_nxt;
	logic [CNT_W-1:0]           onsets_nxt;
	logic [CNT_W-1:0]           seen_inc;
	logic                       burst_nxt;

	assign cfg.ready = 1'b1;
	// a pending register write goes first
	assign smp.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign accept    = smp.valid && smp.ready;
	assign close     = (CMP_W'(seen_q) > CMP_W'(window_q)) || (seen_q == '1);
	assign fin_load  = (state_q == ST_FIN) && (!ovalid_q || res.ready);

	// shared multiplier: period product, then the two threshold products
	assign range_w = (S+1)'(lmax_q) - (S+1)'(lmin_q);

	always_comb begin
		case (state_q)
			ST_MUL: begin
				mul_a = MA_W'($signed({1'b0, num_q}));
				mul_b = MB_W'($signed({1'b0, period_q}));
			end
			ST_TLO: begin
				mul_a = MA_W'(range_w);
				mul_b = LO_FACTOR;
			end
			default: begin
				mul_a = MA_W'(range_w);
				mul_b = HI_FACTOR;
			end
		endcase
	end

	// round to nearest, ties up, then clamp to the sample range
	always_comb begin
		rnd     = prod_q + P_W'(ROUND_BIAS);
		thr_sum = (rnd >>> FRAC_BITS) + P_W'(lmin_q);
		if (thr_sum > P_W'(SMAX)) begin
			thr_val = SMAX;
		end else if (thr_sum < P_W'(SMIN)) begin
			thr_val = SMIN;
		end else begin
			thr_val = thr_sum[S-1:0];
		end
	end

	assign div_start = (state_q == ST_DIV_GO);

	bwa_div #(
		.NUM_W (NUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q[NUM_W-1:0]),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign quo_ext    = QW'(div_quo);
	assign period_sat = (|quo_ext[QW-1:PERIOD_OUT_BITS]) ? '1 : quo_ext[PERIOD_OUT_BITS-1:0];

	// burst detector and window counters
	always_comb begin
		onset      = !burst_q && (s_q > hi_q);
		release_b  = burst_q && (s_q < lo_q);
		gap        = (seen_q >= last_q) ? seen_q - last_q : '0;
		isum_sum   = {1'b0, isum_q} + {1'b0, gap};
		isum_nxt   = isum_sum[CNT_W] ? '1 : isum_sum[CNT_W-1:0];
		onsets_nxt = (onset && onsets_q != '1) ? onsets_q + 1'b1 : onsets_q;
		seen_inc   = (seen_q == '1) ? seen_q : seen_q + 1'b1;
		burst_nxt  = onset ? 1'b1 : (release_b ? 1'b0 : burst_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			window_q  <= WINDOW_RESET;
			period_q  <= PERIOD_RESET;
			run_min_q <= SMAX;
			run_max_q <= SMIN;
			lmin_q    <= '0;
			lmax_q    <= '0;
			seen_q    <= '0;
			onsets_q  <= '0;
			isum_q    <= '0;
			last_q    <= '0;
			burst_q   <= 1'b0;
			lperiod_q <= '0;
			lvalid_q  <= 1'b0;
			closed_q  <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_WINDOW:   window_q <= cfg.data[WINDOW_BITS-1:0];
					REG_PERIOD:   period_q <= cfg.data[PERIOD_BITS-1:0];
					REG_INIT_MIN: lmin_q   <= cfg.data[S-1:0];
					REG_INIT_MAX: lmax_q   <= cfg.data[S-1:0];
					default: ;
				endcase
			end

			if (fin_load) begin
				ovalid_q <= 1'b1;
			end else if (res.valid && res.ready) begin
				ovalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						closed_q <= close;
						if (close) begin
							lmin_q    <= run_min_q;
							lmax_q    <= run_max_q;
							run_min_q <= smp.sample;
							run_max_q <= smp.sample;
							seen_q    <= '0;
							onsets_q  <= '0;
							isum_q    <= '0;
							last_q    <= '0;
							if (onsets_q == '0) begin
								lperiod_q <= '0;
								lvalid_q  <= 1'b0;
								state_q   <= ST_TLO;
							end else begin
								state_q <= ST_MUL;
							end
						end else begin
							if (smp.sample < run_min_q) begin
								run_min_q <= smp.sample;
							end
							if (smp.sample > run_max_q) begin
								run_max_q <= smp.sample;
							end
							state_q <= ST_TLO;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						lperiod_q <= period_sat;
						lvalid_q  <= 1'b1;
						state_q   <= ST_TLO;
					end
				end
				ST_TLO: begin
					state_q <= ST_THI;
				end
				ST_THI: begin
					state_q <= ST_THR;
				end
				ST_THR: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_load) begin
						burst_q  <= burst_nxt;
						onsets_q <= onsets_nxt;
						seen_q   <= seen_inc;
						if (onset) begin
							isum_q <= isum_nxt;
							last_q <= seen_q;
						end
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			s_q   <= smp.sample;
			num_q <= isum_q;
			den_q <= onsets_q;
		end
		if (state_q == ST_THI) begin
			lo_q <= thr_val;
		end
		if (state_q == ST_THR) begin
			hi_q <= thr_val;
		end
		if (fin_load) begin
			o_min_q    <= lmin_q;
			o_max_q    <= lmax_q;
			o_lo_q     <= lo_q;
			o_hi_q     <= hi_q;
			o_burst_q  <= burst_nxt;
			o_onsets_q <= onsets_nxt;
			o_seen_q   <= seen_inc;
		end
	end

	// period and flag set only at a close, closed_q per sample, before the load
	logic [PERIOD_OUT_BITS-1:0] o_period_q;
	logic                       o_pvalid_q;
	logic                       o_closed_q;

	always_ff @(posedge clk) begin
		if (fin_load) begin
			o_period_q <= lperiod_q;
			o_pvalid_q <= lvalid_q;
			o_closed_q <= closed_q;
		end
	end

	assign res.valid           = ovalid_q;
	assign res.held_min        = o_min_q;
	assign res.held_max        = o_max_q;
	assign res.low_threshold   = o_lo_q;
	assign res.high_threshold  = o_hi_q;
	assign res.in_burst        = o_burst_q;
	assign res.burst_count     = o_onsets_q;
	assign res.point_count     = o_seen_q;
	assign res.burst_period_us = o_period_q;
	assign res.period_valid    = o_pvalid_q;
	assign res.window_closed   = o_closed_q;

endmodule

`default_nettype wire

// ===== rtl/core/bwa_checker.sv =====
`default_nettype none

module bwa_checker #(
	parameter int SAMPLE_BITS = bwa_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = bwa_pkg::COUNT_BITS_DEF
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                smp_valid,
	input wire logic                                smp_ready,
	input wire logic                                res_valid,
	input wire logic                                res_ready,
	input wire logic signed [SAMPLE_BITS-1:0]       held_min,
	input wire logic [COUNT_BITS-1:0]               burst_count,
	input wire logic [COUNT_BITS-1:0]               point_count,
	input wire logic [bwa_pkg::PERIOD_OUT_BITS-1:0] burst_period_us,
	input wire logic                                period_valid,
	input wire logic                                window_closed
);
	import bwa_pkg::*;

	// one sample in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready)
		else $error("sample accepted while previous still in work");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(held_min) && $stable(point_count))
		else $error("stalled result changed");

	a_close_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && window_closed |-> point_count == COUNT_BITS'(1))
		else $error("closing sample does not restart the window count");

	a_onsets_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> burst_count <= point_count)
		else $error("more burst onsets than samples in window");

	a_period_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !period_valid |-> burst_period_us == '0)
		else $error("nonzero period without a valid flag");

endmodule

bind burst_window_analyzer_core bwa_checker #(
	.SAMPLE_BITS (SAMPLE_BITS),
	.COUNT_BITS  (COUNT_BITS)
) u_bwa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.smp_valid       (smp.valid),
	.smp_ready       (smp.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.held_min        (res.held_min),
	.burst_count     (res.burst_count),
	.point_count     (res.point_count),
	.burst_period_us (res.burst_period_us),
	.period_valid    (res.period_valid),
	.window_closed   (res.window_closed)
);

`default_nettype wire

// ===== bench/burst_window_analyzer_core_tb.sv =====
`timescale 1ns / 100ps

module burst_window_analyzer_core_tb;
	import bwa_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int CB = COUNT_BITS_DEF;
	localparam int PROD_BITS = CB + PERIOD_BITS;
	localparam logic signed [SB-1:0] SMP_TOP    = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMP_BOTTOM = {1'b1, {(SB-1){1'b0}}};
	localparam logic [CFG_IDX_BITS-1:0] IDX_UNUSED_LOW = CFG_IDX_BITS'(4);
	localparam logic [CFG_IDX_BITS-1:0] IDX_UNUSED_TOP = '1;
	localparam int RANDOM_ITEMS = 1750;
	localparam int END_PAUSE    = 64;
	localparam int TIMEOUT_NS   = 100_000_000;
	localparam int PRINT_CAP    = 200;

	typedef struct {
		logic signed [SB-1:0]         held_min;
		logic signed [SB-1:0]         held_max;
		logic signed [SB-1:0]         low_threshold;
		logic signed [SB-1:0]         high_threshold;
		logic                         in_burst;
		logic [CB-1:0]                burst_count;
		logic [CB-1:0]                point_count;
		logic [PERIOD_OUT_BITS-1:0]   burst_period_us;
		logic                         period_valid;
		logic                         window_closed;
	} readout_t;

	class burst_window_scoreboard;
		logic [WINDOW_BITS-1:0]     window_len;
		logic [PERIOD_BITS-1:0]     period_us;
		logic signed [SB-1:0]       run_lo;
		logic signed [SB-1:0]       run_hi;
		logic signed [SB-1:0]       held_lo;
		logic signed [SB-1:0]       held_hi;
		logic [CB-1:0]              n_samples;
		logic [CB-1:0]              n_onsets;
		logic [CB-1:0]              gap_sum;
		logic [CB-1:0]              onset_at;
		bit                         burst_on;
		bit                         held_valid;
		logic [PERIOD_OUT_BITS-1:0] held_period;
		readout_t                   pending_readouts[$];
		int                         fail_count;

		function new();
			window_len  = WINDOW_RESET;
			period_us   = PERIOD_RESET;
			run_lo      = SMP_TOP;
			run_hi      = SMP_BOTTOM;
			held_lo     = '0;
			held_hi     = '0;
			n_samples   = '0;
			n_onsets    = '0;
			gap_sum     = '0;
			onset_at    = '0;
			burst_on    = 1'b0;
			held_valid  = 1'b0;
			held_period = '0;
			fail_count  = 0;
		endfunction

		function int pending();
			return pending_readouts.size();
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
			case (idx)
				REG_WINDOW:   window_len = d[WINDOW_BITS-1:0];
				REG_PERIOD:   period_us = d[PERIOD_BITS-1:0];
				REG_INIT_MIN: held_lo = d[SB-1:0];
				REG_INIT_MAX: held_hi = d[SB-1:0];
				default: ;
			endcase
		endfunction

		// held min plus a q16 fraction of the held range, rounded, clamped
		function logic signed [SB-1:0] level_at(longint factor);
			longint span;
			longint lvl;
			span = longint'(held_hi) - longint'(held_lo);
			lvl = longint'(held_lo) + ((span * factor + ROUND_BIAS) >>> FRAC_BITS);
			if (lvl > longint'(SMP_TOP))
				lvl = longint'(SMP_TOP);
			if (lvl < longint'(SMP_BOTTOM))
				lvl = longint'(SMP_BOTTOM);
			return lvl[SB-1:0];
		endfunction

		function logic [CB-1:0] bump(logic [CB-1:0] c);
			return (&c) ? c : c + 1'b1;
		endfunction

		function void take_sample(logic signed [SB-1:0] s);
			readout_t r;
			logic [PROD_BITS-1:0] prod;
			logic [PROD_BITS-1:0] quo;
			logic [CB:0] sum;
			logic [CB-1:0] gap;
			logic signed [SB-1:0] lo;
			logic signed [SB-1:0] hi;
			r.window_closed = (n_samples > window_len) || (&n_samples);
			if (r.window_closed) begin
				held_lo = run_lo;
				held_hi = run_hi;
				run_lo = SMP_TOP;
				run_hi = SMP_BOTTOM;
				if (n_onsets == '0) begin
					held_period = '0;
					held_valid = 1'b0;
				end else begin
					prod = PROD_BITS'(gap_sum) * PROD_BITS'(period_us);
					quo = prod / PROD_BITS'(n_onsets);
					held_period = (|quo[PROD_BITS-1:PERIOD_OUT_BITS]) ? '1
						: quo[PERIOD_OUT_BITS-1:0];
					held_valid = 1'b1;
				end
				n_samples = '0;
				n_onsets = '0;
				gap_sum = '0;
				onset_at = '0;
			end
			if (s < run_lo)
				run_lo = s;
			if (s > run_hi)
				run_hi = s;
			lo = level_at(longint'(LO_FACTOR));
			hi = level_at(longint'(HI_FACTOR));
			if (!burst_on && s > hi) begin
				gap = (n_samples >= onset_at) ? n_samples - onset_at : '0;
				burst_on = 1'b1;
				n_onsets = bump(n_onsets);
				sum = {1'b0, gap_sum} + {1'b0, gap};
				gap_sum = sum[CB] ? '1 : sum[CB-1:0];
				onset_at = n_samples;
			end else if (burst_on && s < lo) begin
				burst_on = 1'b0;
			end
			n_samples = bump(n_samples);
			r.held_min = held_lo;
			r.held_max = held_hi;
			r.low_threshold = lo;
			r.high_threshold = hi;
			r.in_burst = burst_on;
			r.burst_count = n_onsets;
			r.point_count = n_samples;
			r.burst_period_us = held_period;
			r.period_valid = held_valid;
			pending_readouts.push_back(r);
		endfunction

		task report(string what);
			fail_count++;
			if (fail_count <= PRINT_CAP)
				$display("%0t mismatch: %s", $time, what);
		endtask

		task compare(string field, logic [63:0] g, logic [63:0] w);
			if (g !== w)
				report($sformatf("%s got %0h expected %0h", field, g, w));
		endtask

		task check_result(readout_t got);
			readout_t want;
			if (pending_readouts.size() == 0) begin
				report("result with no sample pending");
				return;
			end
			want = pending_readouts.pop_front();
			compare("held_min", 64'(got.held_min), 64'(want.held_min));
			compare("held_max", 64'(got.held_max), 64'(want.held_max));
			compare("low_threshold", 64'(got.low_threshold), 64'(want.low_threshold));
			compare("high_threshold", 64'(got.high_threshold), 64'(want.high_threshold));
			compare("in_burst", 64'(got.in_burst), 64'(want.in_burst));
			compare("burst_count", 64'(got.burst_count), 64'(want.burst_count));
			compare("point_count", 64'(got.point_count), 64'(want.point_count));
			compare("burst_period_us", 64'(got.burst_period_us),
				64'(want.burst_period_us));
			compare("period_valid", 64'(got.period_valid), 64'(want.period_valid));
			compare("window_closed", 64'(got.window_closed), 64'(want.window_closed));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bwa_cfg_if cfg_bus ();
	bwa_smp_if #(.SAMPLE_BITS(SB)) smp_bus ();
	bwa_res_if #(.SAMPLE_BITS(SB), .COUNT_BITS(CB)) res_bus ();

	burst_window_analyzer_core #(
		.SAMPLE_BITS(SB),
		.COUNT_BITS(CB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.smp(smp_bus),
		.res(res_bus)
	);

	burst_window_scoreboard sb;

	bit       no_gaps;
	int       hold_req;
	int       hold_left;
	int       rx_wait;
	readout_t got;

	// waveform shaping for the random part
	int  seg_left;
	bit  seg_high;
	int  lvl_lo;
	int  lvl_hi;
	int  jitter;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			got.held_min = res_bus.held_min;
			got.held_max = res_bus.held_max;
			got.low_threshold = res_bus.low_threshold;
			got.high_threshold = res_bus.high_threshold;
			got.in_burst = res_bus.in_burst;
			got.burst_count = res_bus.burst_count;
			got.point_count = res_bus.point_count;
			got.burst_period_us = res_bus.burst_period_us;
			got.period_valid = res_bus.period_valid;
			got.window_closed = res_bus.window_closed;
			sb.check_result(got);
		end
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		// long hold-off so the block backs up and stalls its sample input
		if (hold_left != 0) begin
			hold_left--;
			res_bus.ready <= 1'b0;
		end else if (rx_wait != 0) begin
			rx_wait--;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= 1'b1;
			if (!no_gaps)
				rx_wait = pick_gap();
		end
	end

	function automatic logic signed [SB-1:0] next_wave();
		int v;
		if (seg_left == 0) begin
			seg_high = !seg_high;
			seg_left = $urandom_range(1, 12);
		end
		seg_left--;
		case ($urandom_range(0, 19))
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = $urandom_range(0, 1) ? int'(SMP_TOP) : int'(SMP_BOTTOM);
			default: v = (seg_high ? lvl_hi : lvl_lo) + int'($urandom_range(0, 2 * jitter))
				- jitter;
		endcase
		if (v > int'(SMP_TOP))
			v = int'(SMP_TOP);
		if (v < int'(SMP_BOTTOM))
			v = int'(SMP_BOTTOM);
		return v[SB-1:0];
	endfunction

	task automatic send_sample(input logic signed [SB-1:0] v);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap != 0) begin
			smp_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_bus.valid <= 1'b1;
		smp_bus.sample <= v;
		do begin
			@(posedge clk);
		end while (smp_bus.ready !== 1'b1);
		sb.take_sample(v);
	endtask

	task automatic drain_results();
		smp_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] d);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= d;
		do begin
			@(posedge clk);
		end while (cfg_bus.ready !== 1'b1);
		sb.write_reg(idx, d);
	endtask

	// junk in the unused upper data bits must be dropped by the block
	task automatic set_regs(input logic [WINDOW_BITS-1:0] w, input logic [PERIOD_BITS-1:0] p,
		input logic signed [SB-1:0] mn, input logic signed [SB-1:0] mx, input bit stray);
		put_reg(REG_WINDOW, {(CFG_DATA_BITS-WINDOW_BITS)'($urandom), w});
		put_reg(REG_PERIOD, {(CFG_DATA_BITS-PERIOD_BITS)'($urandom), p});
		put_reg(REG_INIT_MIN, {(CFG_DATA_BITS-SB)'($urandom), mn});
		put_reg(REG_INIT_MAX, {(CFG_DATA_BITS-SB)'($urandom), mx});
		if (stray)
			put_reg($urandom_range(0, 1) ? IDX_UNUSED_LOW : IDX_UNUSED_TOP, $urandom);
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin : main
		int random_items;
		int phase_no;
		int n;
		logic [WINDOW_BITS-1:0] w;
		logic [PERIOD_BITS-1:0] p;
		logic signed [SB-1:0] mn;
		logic signed [SB-1:0] mx;

		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		smp_bus.valid = 1'b0;
		smp_bus.sample = '0;
		res_bus.ready = 1'b0;
		no_gaps = 1'b0;
		hold_req = 0;
		hold_left = 0;
		rx_wait = 0;
		seg_left = 0;
		seg_high = 1'b0;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight out of reset
		send_sample(SB'(0));
		send_sample(SMP_BOTTOM);
		send_sample(SMP_TOP);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		drain_results();

		// full-scale held range, short window, longest period, stray index
		set_regs(WINDOW_BITS'(3), '1, SMP_BOTTOM, SMP_TOP, 1'b1);
		send_sample(SB'(0));
		send_sample(SMP_TOP);
		send_sample(SMP_BOTTOM);
		send_sample(SMP_TOP);
		send_sample(SB'(100));
		send_sample(SB'(0));
		send_sample(SB'(0));
		send_sample(SB'(0));
		send_sample(SB'(0));
		send_sample(SMP_BOTTOM);
		drain_results();

		// inverted held range, zero window and zero period
		set_regs('0, '0, SB'(1000), SB'(-1000), 1'b0);
		send_sample(SB'(500));
		send_sample(SB'(-500));
		send_sample(SB'(2000));
		send_sample(SB'(-2000));
		send_sample(SB'(0));
		send_sample(SB'(900));
		send_sample(SB'(-900));
		send_sample(SB'(3));
		drain_results();

		random_items = 0;
		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: w = '0;
				1: w = WINDOW_BITS'(1);
				2: w = '1;
				3: w = WINDOW_BITS'($urandom_range(100, 300));
				default: w = WINDOW_BITS'($urandom_range(2, 60));
			endcase
			case ($urandom_range(0, 7))
				0: p = '0;
				1: p = PERIOD_BITS'(1);
				2: p = '1;
				default: p = PERIOD_BITS'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 5))
				0: begin
					mn = SMP_BOTTOM;
					mx = SMP_TOP;
				end
				1: begin
					mn = SMP_TOP;
					mx = SMP_BOTTOM;
				end
				default: begin
					mn = SB'($urandom);
					mx = SB'($urandom);
				end
			endcase
			set_regs(w, p, mn, mx, $urandom_range(0, 3) == 0);
			no_gaps = ($urandom_range(0, 3) == 0);
			if (phase_no % 4 == 1)
				hold_req = $urandom_range(150, 400);
			lvl_lo = -int'($urandom_range(2000, 25000));
			lvl_hi = $urandom_range(2000, 25000);
			jitter = $urandom_range(0, 3000);
			seg_left = 0;
			n = $urandom_range(60, 200);
			repeat (n) send_sample(next_wave());
			drain_results();
			random_items += n;
			phase_no++;
		end

		// force a window close with samples that can never start a burst
		no_gaps = 1'b1;
		set_regs('0, '1, SB'(-100), SB'(100), 1'b0);
		send_sample(SMP_BOTTOM);
		send_sample(SMP_BOTTOM);
		drain_results();

		repeat (END_PAUSE) @(posedge clk);
		if (sb.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

endmodule
